### src/mcrf_pkg.sv
package mcrf_pkg;

   // Storage sizes. The SRAM window aliases on the low offset bits, so its size is a power of two.
   localparam int SRAM_BYTES    = 65536;
   localparam int SRAM_AW       = $clog2(SRAM_BYTES);
   localparam int RX_DEPTH      = 1024;
   localparam int RX_AW         = $clog2(RX_DEPTH);
   localparam int RX_CW         = RX_AW + 1;
   localparam int TX_DEPTH      = 1024;
   localparam int TX_AW         = $clog2(TX_DEPTH);
   localparam int TX_CW         = TX_AW + 1;
   localparam int GEN_REGS      = 192;
   localparam int GEN_AW        = $clog2(GEN_REGS);
   localparam int MODEM_ENTRIES = 64;
   localparam int MODEM_AW      = $clog2(MODEM_ENTRIES);

   // Item commands.
   localparam logic [2:0] CMD_READ      = 3'd0;
   localparam logic [2:0] CMD_WRITE     = 3'd1;
   localparam logic [2:0] CMD_LINE_BYTE = 3'd2;
   localparam logic [2:0] CMD_TAKE_TX   = 3'd3;
   localparam logic [2:0] CMD_CONNECT   = 3'd4;
   localparam logic [2:0] CMD_HANG_UP   = 3'd5;

   // Address map.
   localparam logic [7:0]  IO_BANK      = 8'hFB;
   localparam logic [15:0] WIN_BASE     = 16'hC000;
   localparam logic [15:0] WIN_END      = 16'hFE00;
   localparam logic [15:0] SRAM_IO_TOP  = 16'hBFFF;
   localparam logic [15:0] KILL_OFF     = 16'hFE01;
   localparam logic [15:0] CONTROL_OFF  = 16'hFE03;

   // General register numbers.
   localparam logic [7:0] REG_FIXED_HI = 8'h7D;
   localparam logic [7:0] REG_FIXED_LO = 8'hB4;
   localparam logic [7:0] REG_TX_DATA  = 8'h90;
   localparam logic [7:0] REG_RX_DATA  = 8'h94;
   localparam logic [7:0] REG_RX_READY = 8'h98;
   localparam logic [7:0] REG_ZERO     = 8'hA0;
   localparam logic [7:0] REG_MODEM    = 8'hC0;

   // Modem register file entries.
   localparam logic [5:0] M_RELAY   = 6'h07;
   localparam logic [5:0] M_DIAL    = 6'h08;
   localparam logic [5:0] M_ST09    = 6'h09;
   localparam logic [5:0] M_LINE    = 6'h0B;
   localparam logic [5:0] M_ST0D    = 6'h0D;
   localparam logic [5:0] M_ST0E    = 6'h0E;
   localparam logic [5:0] M_ST0F    = 6'h0F;
   localparam logic [5:0] M_MODE    = 6'h12;
   localparam logic [5:0] M_ST19    = 6'h19;
   localparam logic [5:0] M_ST1C    = 6'h1C;
   localparam logic [5:0] M_ST1D    = 6'h1D;
   localparam logic [5:0] M_MASK_A  = 6'h1E;
   localparam logic [5:0] M_MASK_B  = 6'h1F;

   // Fixed values.
   localparam logic [7:0] FIXED_HI_VAL = 8'h80;
   localparam logic [7:0] FIXED_LO_VAL = 8'h7F;
   localparam logic [7:0] M19_RESET    = 8'h46;
   localparam logic [7:0] MODE_KEY     = 8'h84;
   localparam logic [7:0] MASK_A_VAL   = 8'h24;
   localparam logic [7:0] MASK_B_VAL   = 8'h14;
   localparam logic [7:0] STATUS_BIT   = 8'h08;
   localparam logic [7:0] M0D_VAL      = 8'h08;
   localparam logic [7:0] M0E_VAL      = 8'h03;
   localparam logic [7:0] M0F_VAL      = 8'hA0;
   localparam logic [6:0] STREAK_CAP   = 7'd127;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_HANDSHAKE,
      PHASE_CONNECTED
   } phase_type;

   typedef enum logic [2:0] {
      SRC_CONST,
      SRC_SRAM,
      SRC_RX,
      SRC_GEN,
      SRC_MODEM
   } rd_src_type;

   // Item held between memory read and result.
   typedef struct packed {
      rd_src_type           src;
      logic [7:0]           const_rd;
      logic                 status_or;
      logic [7:0]           reset_val;
      logic                 tx_valid;
      logic                 rx_acc;
      logic                 hung;
      logic                 sram_wr;
      logic [7:0]           wd;
      logic [SRAM_AW-1:0]   sram_idx;
   } stage_type;

   function automatic logic [7:0] modem_reset(input logic [5:0] m);
      modem_reset = (m == M_ST19) ? M19_RESET : 8'h00;
   endfunction

endpackage

### src/modem_cart_register_file.sv
// Bus-side register file of a cartridge modem.
// Input channel req_*: one item per transfer (bus read, bus write, received line byte,
// transmit byte request, connect, hang up). Result channel rsp_*: exactly one result
// per item, in order.
// An item passes from the input transfer into the read stage register and then into the
// output register, which drives rsp_valid. Throughput is one item per cycle while rsp_stall
// is low: scalar link state is updated in the cycle of the transfer, the memories are read
// in that cycle and the result is formed from the registered read data in the read stage,
// where the SRAM read-compare-write takes place. An SRAM write followed at once by an access
// to the same byte is served by forwarding.
// After reset the SRAM is cleared by a pass over all SRAM_BYTES bytes (65536), one byte per
// cycle, while req_stall is held high. Register files start at their reset values by
// means of written flags; the receive and transmit buffers start empty.
// When the receiver stalls, the result holds in the output register and one further item
// is taken into the read stage; req_stall rises when both are occupied and during clearing.
module modem_cart_register_file (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [23:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_line_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_rx_accepted,
   output logic        rsp_sram_changed,
   output logic        rsp_hung_up
);

   // Memories.
   logic [7:0] sram_mem  [mcrf_pkg::SRAM_BYTES];
   logic [7:0] gen_mem   [mcrf_pkg::GEN_REGS];
   logic [7:0] modem_mem [mcrf_pkg::MODEM_ENTRIES];
   logic [7:0] rx_mem    [mcrf_pkg::RX_DEPTH];
   logic [7:0] tx_mem    [mcrf_pkg::TX_DEPTH];

   logic [7:0] sram_q_ff, gen_q_ff, modem_q_ff, rx_q_ff, tx_q_ff;

   // Written flags of the register files.
   logic [mcrf_pkg::GEN_REGS-1:0]      gen_wr_ff;
   logic [mcrf_pkg::MODEM_ENTRIES-1:0] modem_wr_ff;
   logic gen_seen_ff, modem_seen_ff;

   // Scalar state.
   logic [mcrf_pkg::RX_CW-1:0] rx_fill_ff, rx_fill_in, rx_taken_ff, rx_taken_in;
   logic [mcrf_pkg::TX_CW-1:0] tx_fill_ff, tx_fill_in, tx_taken_ff, tx_taken_in;
   logic [6:0]                 streak_ff, streak_in;
   mcrf_pkg::phase_type        phase_ff, phase_in;
   logic link_up_ff, link_up_in, relay_ff, relay_in, mode_ff, mode_in;
   logic [7:0] kill_ff, kill_in, control_ff, control_in;

   // Clearing pass.
   logic                        clearing_ff;
   logic [mcrf_pkg::SRAM_AW-1:0] clr_cnt_ff;

   // Pipeline.
   logic                s1_valid_ff;
   mcrf_pkg::stage_type s1_ff, s1_in;
   logic                fwd_ff, fwd_in;
   logic [7:0]          fwd_data_ff;
   logic                out_valid_ff;
   logic [7:0]          out_rd_ff, out_txb_ff;
   logic                out_txv_ff, out_rxa_ff, out_chg_ff, out_hung_ff;

   logic accept, s1_move;

   // Decode of the incoming item.
   logic [7:0]                    bank;
   logic [15:0]                   off;
   logic [7:0]                    reg_no;
   logic [5:0]                    m_no;
   logic [mcrf_pkg::SRAM_AW-1:0]  sram_idx;
   logic [mcrf_pkg::GEN_AW-1:0]   gen_idx;
   logic in_sram, in_win;
   logic gen_we, modem_we, rx_we, tx_we;
   logic [7:0] modem_wd;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;

   assign bank     = req_bus_address[23:16];
   assign off      = req_bus_address[15:0];
   assign reg_no   = off[8:1];
   assign m_no     = reg_no[5:0];
   assign sram_idx = off[mcrf_pkg::SRAM_AW-1:0];
   assign gen_idx  = reg_no[mcrf_pkg::GEN_AW-1:0];
   assign in_sram  = (bank >= 8'hE0 && bank <= 8'hFA)
                  || (bank == mcrf_pkg::IO_BANK && off <= mcrf_pkg::SRAM_IO_TOP)
                  || (bank >= 8'hFC)
                  || (bank >= 8'h60 && bank <= 8'h7D);
   assign in_win   = bank == mcrf_pkg::IO_BANK && off >= mcrf_pkg::WIN_BASE
                  && off < mcrf_pkg::WIN_END;

   // Item decode, scalar state update and result selection.
   always_comb begin
      rx_fill_in  = rx_fill_ff;
      rx_taken_in = rx_taken_ff;
      tx_fill_in  = tx_fill_ff;
      tx_taken_in = tx_taken_ff;
      streak_in   = streak_ff;
      phase_in    = phase_ff;
      link_up_in  = link_up_ff;
      relay_in    = relay_ff;
      mode_in     = mode_ff;
      kill_in     = kill_ff;
      control_in  = control_ff;
      gen_we      = 1'b0;
      modem_we    = 1'b0;
      modem_wd    = req_write_data;
      rx_we       = 1'b0;
      tx_we       = 1'b0;
      s1_in.src       = mcrf_pkg::SRC_CONST;
      s1_in.const_rd  = 8'h00;
      s1_in.status_or = 1'b0;
      s1_in.reset_val = mcrf_pkg::modem_reset(m_no);
      s1_in.tx_valid  = 1'b0;
      s1_in.rx_acc    = 1'b0;
      s1_in.hung      = 1'b0;
      s1_in.sram_wr   = 1'b0;
      s1_in.wd        = req_write_data;
      s1_in.sram_idx  = sram_idx;
      case (req_cmd)
         mcrf_pkg::CMD_READ: begin
            if (in_sram) begin
               s1_in.src = mcrf_pkg::SRC_SRAM;
            end else if (bank == mcrf_pkg::IO_BANK && off == mcrf_pkg::KILL_OFF) begin
               s1_in.const_rd = kill_ff;
            end else if (bank == mcrf_pkg::IO_BANK && off == mcrf_pkg::CONTROL_OFF) begin
               s1_in.const_rd = control_ff;
            end else if (in_win) begin
               if (reg_no == mcrf_pkg::REG_FIXED_HI) begin
                  s1_in.const_rd = mcrf_pkg::FIXED_HI_VAL;
               end else if (reg_no == mcrf_pkg::REG_FIXED_LO) begin
                  s1_in.const_rd = mcrf_pkg::FIXED_LO_VAL;
               end else if (reg_no == mcrf_pkg::REG_RX_DATA) begin
                  // Pop one receive byte; the buffer goes back to empty once drained.
                  if (rx_taken_ff < rx_fill_ff) begin
                     s1_in.src   = mcrf_pkg::SRC_RX;
                     rx_taken_in = rx_taken_ff + 1'b1;
                     if (rx_taken_in == rx_fill_ff) begin
                        rx_taken_in = '0;
                        rx_fill_in  = '0;
                     end
                  end
               end else if (reg_no == mcrf_pkg::REG_RX_READY) begin
                  // Ready answers are capped after a long run of yes.
                  if (phase_ff != mcrf_pkg::PHASE_IDLE && rx_taken_ff < rx_fill_ff) begin
                     streak_in = streak_ff + 1'b1;
                     if (streak_in == mcrf_pkg::STREAK_CAP) begin
                        streak_in = '0;
                     end else begin
                        s1_in.const_rd = 8'h01;
                     end
                  end else begin
                     streak_in = '0;
                  end
               end else if (reg_no == mcrf_pkg::REG_ZERO) begin
                  s1_in.const_rd = 8'h00;
               end else if (reg_no >= mcrf_pkg::REG_MODEM) begin
                  case (m_no)
                     mcrf_pkg::M_ST09, mcrf_pkg::M_ST19, mcrf_pkg::M_ST1C,
                     mcrf_pkg::M_ST1D, mcrf_pkg::M_MASK_B: begin
                        s1_in.src = mcrf_pkg::SRC_MODEM;
                     end
                     mcrf_pkg::M_MASK_A: begin
                        s1_in.src       = mcrf_pkg::SRC_MODEM;
                        s1_in.status_or = 1'b1;
                     end
                     mcrf_pkg::M_LINE: begin
                        s1_in.const_rd = {relay_ff, 2'b00, mode_ff, 4'h0};
                        mode_in        = 1'b0;
                     end
                     mcrf_pkg::M_ST0D: s1_in.const_rd = mcrf_pkg::M0D_VAL;
                     mcrf_pkg::M_ST0E: s1_in.const_rd = mcrf_pkg::M0E_VAL;
                     mcrf_pkg::M_ST0F: s1_in.const_rd = mcrf_pkg::M0F_VAL;
                     default: s1_in.const_rd = 8'h00;
                  endcase
               end else begin
                  s1_in.src = mcrf_pkg::SRC_GEN;
               end
            end
         end
         mcrf_pkg::CMD_WRITE: begin
            if (in_sram) begin
               s1_in.sram_wr = 1'b1;
            end else if (bank == mcrf_pkg::IO_BANK && off == mcrf_pkg::KILL_OFF) begin
               kill_in = req_write_data;
            end else if (bank == mcrf_pkg::IO_BANK && off == mcrf_pkg::CONTROL_OFF) begin
               control_in = req_write_data;
            end else if (in_win) begin
               // Transmit data is queued while a link is being set up or is up.
               if (reg_no == mcrf_pkg::REG_TX_DATA && phase_ff != mcrf_pkg::PHASE_IDLE
                   && tx_fill_ff < mcrf_pkg::TX_CW'(mcrf_pkg::TX_DEPTH)) begin
                  tx_we      = 1'b1;
                  tx_fill_in = tx_fill_ff + 1'b1;
               end
               if (reg_no >= mcrf_pkg::REG_MODEM) begin
                  case (m_no)
                     mcrf_pkg::M_RELAY: begin
                        relay_in = req_write_data[1];
                        if (!req_write_data[1] && phase_ff != mcrf_pkg::PHASE_IDLE) begin
                           link_up_in  = 1'b0;
                           phase_in    = mcrf_pkg::PHASE_IDLE;
                           rx_fill_in  = '0;
                           rx_taken_in = '0;
                           tx_fill_in  = '0;
                           tx_taken_in = '0;
                           s1_in.hung  = 1'b1;
                        end
                     end
                     mcrf_pkg::M_DIAL: begin
                        if (req_write_data[0] && phase_ff == mcrf_pkg::PHASE_IDLE) begin
                           phase_in = mcrf_pkg::PHASE_HANDSHAKE;
                        end
                     end
                     mcrf_pkg::M_MODE: begin
                        if (req_write_data == mcrf_pkg::MODE_KEY) begin
                           mode_in = 1'b1;
                        end
                     end
                     mcrf_pkg::M_MASK_A: begin
                        modem_we = 1'b1;
                        modem_wd = req_write_data & mcrf_pkg::MASK_A_VAL;
                     end
                     mcrf_pkg::M_MASK_B: begin
                        modem_we = 1'b1;
                        modem_wd = req_write_data & mcrf_pkg::MASK_B_VAL;
                     end
                     default: modem_we = 1'b1;
                  endcase
               end else if (req_bus_address[0]) begin
                  gen_we = 1'b1;
               end
            end
         end
         mcrf_pkg::CMD_LINE_BYTE: begin
            if (link_up_ff && rx_fill_ff < mcrf_pkg::RX_CW'(mcrf_pkg::RX_DEPTH)) begin
               rx_we        = 1'b1;
               rx_fill_in   = rx_fill_ff + 1'b1;
               s1_in.rx_acc = 1'b1;
            end
         end
         mcrf_pkg::CMD_TAKE_TX: begin
            if (link_up_ff && tx_taken_ff < tx_fill_ff) begin
               s1_in.tx_valid = 1'b1;
               tx_taken_in    = tx_taken_ff + 1'b1;
               if (tx_taken_in >= tx_fill_ff) begin
                  tx_taken_in = '0;
                  tx_fill_in  = '0;
               end
            end
         end
         mcrf_pkg::CMD_CONNECT: begin
            s1_in.hung  = link_up_ff;
            rx_fill_in  = link_up_ff ? '0 : rx_fill_ff;
            rx_taken_in = link_up_ff ? '0 : rx_taken_ff;
            tx_fill_in  = link_up_ff ? '0 : tx_fill_ff;
            tx_taken_in = link_up_ff ? '0 : tx_taken_ff;
            link_up_in  = 1'b1;
            phase_in    = mcrf_pkg::PHASE_HANDSHAKE;
         end
         mcrf_pkg::CMD_HANG_UP: begin
            link_up_in  = 1'b0;
            phase_in    = mcrf_pkg::PHASE_IDLE;
            rx_fill_in  = '0;
            rx_taken_in = '0;
            tx_fill_in  = '0;
            tx_taken_in = '0;
            s1_in.hung  = 1'b1;
         end
         default: begin
         end
      endcase
      // A byte written back by the item ahead is taken over for the same SRAM byte.
      fwd_in = s1_move && s1_ff.sram_wr && s1_ff.sram_idx == sram_idx;
   end

   // Scalar state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_fill_ff  <= '0;
         rx_taken_ff <= '0;
         tx_fill_ff  <= '0;
         tx_taken_ff <= '0;
         streak_ff   <= '0;
         phase_ff    <= mcrf_pkg::PHASE_IDLE;
         link_up_ff  <= 1'b0;
         relay_ff    <= 1'b0;
         mode_ff     <= 1'b0;
         kill_ff     <= 8'h00;
         control_ff  <= 8'h00;
         gen_wr_ff   <= '0;
         modem_wr_ff <= '0;
      end else if (accept) begin
         rx_fill_ff  <= rx_fill_in;
         rx_taken_ff <= rx_taken_in;
         tx_fill_ff  <= tx_fill_in;
         tx_taken_ff <= tx_taken_in;
         streak_ff   <= streak_in;
         phase_ff    <= phase_in;
         link_up_ff  <= link_up_in;
         relay_ff    <= relay_in;
         mode_ff     <= mode_in;
         kill_ff     <= kill_in;
         control_ff  <= control_in;
         if (gen_we) begin
            gen_wr_ff[gen_idx] <= 1'b1;
         end
         if (modem_we) begin
            modem_wr_ff[m_no] <= 1'b1;
         end
      end
   end

   // Register files, buffers and their registered reads.
   always_ff @(posedge clock) begin
      if (accept) begin
         gen_q_ff      <= gen_mem[gen_idx];
         gen_seen_ff   <= gen_wr_ff[gen_idx];
         modem_q_ff    <= modem_mem[m_no];
         modem_seen_ff <= modem_wr_ff[m_no];
         rx_q_ff       <= rx_mem[rx_taken_ff[mcrf_pkg::RX_AW-1:0]];
         tx_q_ff       <= tx_mem[tx_taken_ff[mcrf_pkg::TX_AW-1:0]];
         if (gen_we) begin
            gen_mem[gen_idx] <= req_write_data;
         end
         if (modem_we) begin
            modem_mem[m_no] <= modem_wd;
         end
         if (rx_we) begin
            rx_mem[rx_fill_ff[mcrf_pkg::RX_AW-1:0]] <= req_line_byte;
         end
         if (tx_we) begin
            tx_mem[tx_fill_ff[mcrf_pkg::TX_AW-1:0]] <= req_write_data;
         end
      end
   end

   // SRAM: read on transfer, write back from the result stage or the clearing pass.
   always_ff @(posedge clock) begin
      if (accept) begin
         sram_q_ff   <= sram_mem[sram_idx];
         fwd_data_ff <= s1_ff.wd;
      end
      if (clearing_ff) begin
         sram_mem[clr_cnt_ff] <= 8'h00;
      end else if (s1_move && s1_ff.sram_wr) begin
         sram_mem[s1_ff.sram_idx] <= s1_ff.wd;
      end
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == mcrf_pkg::SRAM_AW'(mcrf_pkg::SRAM_BYTES - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Read stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         fwd_ff      <= fwd_in;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // Result formation from the registered read data.
   logic [7:0] sram_old, modem_val, rd_val;

   always_comb begin
      sram_old  = fwd_ff ? fwd_data_ff : sram_q_ff;
      modem_val = modem_seen_ff ? modem_q_ff : s1_ff.reset_val;
      if (s1_ff.status_or) begin
         modem_val = modem_val | mcrf_pkg::STATUS_BIT;
      end
      case (s1_ff.src)
         mcrf_pkg::SRC_SRAM:  rd_val = sram_old;
         mcrf_pkg::SRC_RX:    rd_val = rx_q_ff;
         mcrf_pkg::SRC_GEN:   rd_val = gen_seen_ff ? gen_q_ff : 8'h00;
         mcrf_pkg::SRC_MODEM: rd_val = modem_val;
         default:             rd_val = s1_ff.const_rd;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_rd_ff   <= rd_val;
         out_txv_ff  <= s1_ff.tx_valid;
         out_txb_ff  <= s1_ff.tx_valid ? tx_q_ff : 8'h00;
         out_rxa_ff  <= s1_ff.rx_acc;
         out_chg_ff  <= s1_ff.sram_wr && (sram_old != s1_ff.wd);
         out_hung_ff <= s1_ff.hung;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_rd_ff;
   assign rsp_tx_valid     = out_txv_ff;
   assign rsp_tx_byte      = out_txb_ff;
   assign rsp_rx_accepted  = out_rxa_ff;
   assign rsp_sram_changed = out_chg_ff;
   assign rsp_hung_up      = out_hung_ff;

   // Checks.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> req_stall)
      else $error("item transfer possible during SRAM clearing");
   a_rx_order: assert property (@(posedge clock) disable iff (reset)
      rx_taken_ff <= rx_fill_ff)
      else $error("receive buffer taken beyond filled");
   a_tx_order: assert property (@(posedge clock) disable iff (reset)
      tx_taken_ff <= tx_fill_ff)
      else $error("transmit buffer taken beyond filled");
   a_fwd_stage: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("SRAM forwarding flag without an item in the read stage");

endmodule

### tb/sv/modem_cart_register_file_test.sv
module modem_cart_register_file_test;

   timeunit 1ns;
   timeprecision 1ps;

   // Command codes the block leaves unused.
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 60;
   localparam int RANDOM_ITEMS = 640;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [23:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  lbyte;
   } bus_item_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       txv;
      logic [7:0] txb;
      logic       rxa;
      logic       chg;
      logic       hung;
   } bus_result_type;

   // Predicts the bus result of every item and keeps the results still awaited.
   class modem_scoreboard_type;
      logic [7:0]  sram [mcrf_pkg::SRAM_BYTES];
      logic [7:0]  gen [mcrf_pkg::GEN_REGS];
      logic [7:0]  modem [mcrf_pkg::MODEM_ENTRIES];
      logic [7:0]  rx_buf [mcrf_pkg::RX_DEPTH];
      logic [7:0]  tx_buf [mcrf_pkg::TX_DEPTH];
      int          rx_fill, rx_taken, tx_fill, tx_taken, streak;
      mcrf_pkg::phase_type phase;
      bit          link_up, relay, mode;
      logic [7:0]  kill_val, control_val;
      bus_result_type awaited[$];
      int          errors, checked, hangups;

      function void clear();
         foreach (sram[i]) sram[i] = 8'h00;
         foreach (gen[i]) gen[i] = 8'h00;
         gen[mcrf_pkg::REG_FIXED_HI] = mcrf_pkg::FIXED_HI_VAL;
         gen[mcrf_pkg::REG_FIXED_LO] = mcrf_pkg::FIXED_LO_VAL;
         foreach (modem[i]) modem[i] = 8'h00;
         modem[mcrf_pkg::M_ST19] = mcrf_pkg::M19_RESET;
         rx_fill = 0; rx_taken = 0; tx_fill = 0; tx_taken = 0; streak = 0;
         phase = mcrf_pkg::PHASE_IDLE;
         link_up = 0; relay = 0; mode = 0;
         kill_val = 8'h00; control_val = 8'h00;
         errors = 0; checked = 0; hangups = 0;
      endfunction

      function bit sram_hit(logic [7:0] bank, logic [15:0] off);
         return (bank >= 8'hE0 && bank <= 8'hFA) ||
                (bank == mcrf_pkg::IO_BANK && off <= mcrf_pkg::SRAM_IO_TOP) ||
                bank >= 8'hFC || (bank >= 8'h60 && bank <= 8'h7D);
      endfunction

      function void drop_link();
         link_up = 0;
         phase = mcrf_pkg::PHASE_IDLE;
         rx_fill = 0; rx_taken = 0; tx_fill = 0; tx_taken = 0;
      endfunction

      function logic [7:0] read_reg(logic [7:0] r);
         logic [7:0] v;
         logic [5:0] m;
         v = 8'h00;
         m = r[5:0];
         if (r == mcrf_pkg::REG_FIXED_HI) return mcrf_pkg::FIXED_HI_VAL;
         if (r == mcrf_pkg::REG_FIXED_LO) return mcrf_pkg::FIXED_LO_VAL;
         if (r == mcrf_pkg::REG_RX_DATA) begin
            if (rx_taken >= rx_fill) return 8'h00;
            v = rx_buf[rx_taken];
            rx_taken++;
            if (rx_taken == rx_fill) begin
               rx_taken = 0; rx_fill = 0;
            end
            return v;
         end
         if (r == mcrf_pkg::REG_RX_READY) begin
            if (phase != mcrf_pkg::PHASE_IDLE && rx_taken < rx_fill) begin
               streak++;
               if (streak >= int'(mcrf_pkg::STREAK_CAP)) begin
                  streak = 0;
                  return 8'h00;
               end
               return 8'h01;
            end
            streak = 0;
            return 8'h00;
         end
         if (r == mcrf_pkg::REG_ZERO) return 8'h00;
         if (r < mcrf_pkg::REG_MODEM) return gen[r];
         case (m)
            mcrf_pkg::M_ST09, mcrf_pkg::M_ST19, mcrf_pkg::M_ST1C, mcrf_pkg::M_ST1D,
            mcrf_pkg::M_MASK_B: v = modem[m];
            mcrf_pkg::M_MASK_A: v = modem[m] | mcrf_pkg::STATUS_BIT;
            mcrf_pkg::M_LINE: begin
               v = {relay, 2'b00, mode, 4'h0};
               mode = 0;
            end
            mcrf_pkg::M_ST0D: v = mcrf_pkg::M0D_VAL;
            mcrf_pkg::M_ST0E: v = mcrf_pkg::M0E_VAL;
            mcrf_pkg::M_ST0F: v = mcrf_pkg::M0F_VAL;
            default: v = 8'h00;
         endcase
         return v;
      endfunction

      // Works out the result of one accepted item and updates the model state.
      function void note_item(bus_item_type it);
         bus_result_type res;
         logic [7:0]  bank, r;
         logic [15:0] off, rel;
         logic [5:0]  m;
         res = '0;
         bank = it.addr[23:16];
         off = it.addr[15:0];
         rel = off - mcrf_pkg::WIN_BASE;
         r = rel[8:1];
         m = r[5:0];
         case (it.cmd)
            mcrf_pkg::CMD_READ: begin
               if (sram_hit(bank, off)) res.rdata = sram[off];
               else if (bank != mcrf_pkg::IO_BANK) res.rdata = 8'h00;
               else if (off == mcrf_pkg::KILL_OFF) res.rdata = kill_val;
               else if (off == mcrf_pkg::CONTROL_OFF) res.rdata = control_val;
               else if (off >= mcrf_pkg::WIN_BASE && off < mcrf_pkg::WIN_END)
                  res.rdata = read_reg(r);
            end
            mcrf_pkg::CMD_WRITE: begin
               if (sram_hit(bank, off)) begin
                  if (sram[off] != it.wdata) begin
                     sram[off] = it.wdata;
                     res.chg = 1;
                  end
               end else if (bank == mcrf_pkg::IO_BANK) begin
                  if (off == mcrf_pkg::KILL_OFF) kill_val = it.wdata;
                  else if (off == mcrf_pkg::CONTROL_OFF) control_val = it.wdata;
                  else if (off >= mcrf_pkg::WIN_BASE && off < mcrf_pkg::WIN_END) begin
                     if (r == mcrf_pkg::REG_TX_DATA && phase != mcrf_pkg::PHASE_IDLE &&
                         tx_fill < mcrf_pkg::TX_DEPTH) begin
                        tx_buf[tx_fill] = it.wdata;
                        tx_fill++;
                     end
                     if (r >= mcrf_pkg::REG_MODEM) begin
                        case (m)
                           mcrf_pkg::M_RELAY: begin
                              relay = it.wdata[1];
                              if (!relay && phase != mcrf_pkg::PHASE_IDLE) begin
                                 drop_link();
                                 res.hung = 1;
                              end
                           end
                           mcrf_pkg::M_DIAL:
                              if (it.wdata[0] && phase == mcrf_pkg::PHASE_IDLE)
                                 phase = mcrf_pkg::PHASE_HANDSHAKE;
                           mcrf_pkg::M_MODE: if (it.wdata == mcrf_pkg::MODE_KEY) mode = 1;
                           mcrf_pkg::M_MASK_A: modem[m] = it.wdata & mcrf_pkg::MASK_A_VAL;
                           mcrf_pkg::M_MASK_B: modem[m] = it.wdata & mcrf_pkg::MASK_B_VAL;
                           default: modem[m] = it.wdata;
                        endcase
                     end else if (it.addr[0]) begin
                        gen[r] = it.wdata;
                     end
                  end
               end
            end
            mcrf_pkg::CMD_LINE_BYTE: begin
               if (link_up && rx_fill < mcrf_pkg::RX_DEPTH) begin
                  rx_buf[rx_fill] = it.lbyte;
                  rx_fill++;
                  res.rxa = 1;
               end
            end
            mcrf_pkg::CMD_TAKE_TX: begin
               if (link_up && tx_taken < tx_fill) begin
                  res.txb = tx_buf[tx_taken];
                  res.txv = 1;
                  tx_taken++;
                  if (tx_taken >= tx_fill) begin
                     tx_taken = 0; tx_fill = 0;
                  end
               end
            end
            mcrf_pkg::CMD_CONNECT: begin
               if (link_up) begin
                  drop_link();
                  res.hung = 1;
               end
               link_up = 1;
               phase = mcrf_pkg::PHASE_HANDSHAKE;
            end
            mcrf_pkg::CMD_HANG_UP: begin
               drop_link();
               res.hung = 1;
            end
            default: ;
         endcase
         awaited.push_back(res);
      endfunction

      function void report(string field, logic [7:0] want, logic [7:0] got);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      endfunction

      // Compares one result transfer with the oldest prediction.
      function void check_result(bus_result_type got);
         bus_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result transfer with nothing awaited", $time);
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.hung) hangups++;
         if (got.rdata !== want.rdata) report("read_data", want.rdata, got.rdata);
         if (got.txv !== want.txv) report("tx_valid", 8'(want.txv), 8'(got.txv));
         if (got.txb !== want.txb) report("tx_byte", want.txb, got.txb);
         if (got.rxa !== want.rxa) report("rx_accepted", 8'(want.rxa), 8'(got.rxa));
         if (got.chg !== want.chg) report("sram_changed", 8'(want.chg), 8'(got.chg));
         if (got.hung !== want.hung) report("hung_up", 8'(want.hung), 8'(got.hung));
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_cmd = mcrf_pkg::CMD_READ;
   logic [23:0] req_bus_address = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_line_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [7:0]  rsp_read_data;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_rx_accepted;
   logic        rsp_sram_changed;
   logic        rsp_hung_up;

   modem_scoreboard_type modem_sb = new();
   int  cycles = 0;
   int  sent = 0;
   bit  calm = 0;
   bit  hold_request = 0;
   int  hold_left = 0;

   modem_cart_register_file i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Cycle count and time limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: checks each transfer and stalls at random or for a long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         modem_sb.check_result({rsp_read_data, rsp_tx_valid, rsp_tx_byte, rsp_rx_accepted,
                                rsp_sram_changed, rsp_hung_up});
      if (hold_request && hold_left == 0) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
      end
   end

   // Offers one item and waits for its transfer.
   task automatic send_item(bus_item_type it);
      if (!calm) begin
         while ($urandom_range(0, 99) < 36) begin
            req_valid <= 0;
            @(posedge clock);
         end
      end
      req_valid <= 1;
      req_cmd <= it.cmd;
      req_bus_address <= it.addr;
      req_write_data <= it.wdata;
      req_line_byte <= it.lbyte;
      do @(posedge clock); while (req_stall);
      modem_sb.note_item(it);
      sent++;
   endtask

   task automatic send_cmd(logic [2:0] c, logic [23:0] a, logic [7:0] w, logic [7:0] l);
      bus_item_type it;
      it = '{cmd: c, addr: a, wdata: w, lbyte: l};
      send_item(it);
   endtask

   function automatic logic [23:0] reg_addr(logic [7:0] r, bit odd);
      logic [15:0] off;
      off = mcrf_pkg::WIN_BASE + {7'd0, r, odd};
      return {mcrf_pkg::IO_BANK, off};
   endfunction

   function automatic logic [23:0] sram_addr();
      logic [7:0]  bank;
      logic [15:0] off;
      case ($urandom_range(0, 3))
         0: bank = 8'($urandom_range(8'hE0, 8'hFA));
         1: bank = 8'($urandom_range(8'hFC, 8'hFF));
         2: bank = 8'($urandom_range(8'h60, 8'h7D));
         default: bank = mcrf_pkg::IO_BANK;
      endcase
      // Mostly a few bytes so that aliases and unchanged writes occur.
      off = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {12'h000, 4'($urandom)};
      if (bank == mcrf_pkg::IO_BANK && off > mcrf_pkg::SRAM_IO_TOP)
         off = off & mcrf_pkg::SRAM_IO_TOP;
      return {bank, off};
   endfunction

   // Picks a random item, mostly well formed traffic on a live link.
   function automatic bus_item_type random_item();
      bus_item_type it;
      int           pick;
      logic [7:0]   r;
      it.wdata = 8'($urandom);
      it.lbyte = 8'($urandom);
      pick = $urandom_range(0, 99);
      it.cmd = pick < 30 ? mcrf_pkg::CMD_READ : pick < 62 ? mcrf_pkg::CMD_WRITE :
               pick < 76 ? mcrf_pkg::CMD_LINE_BYTE : pick < 88 ? mcrf_pkg::CMD_TAKE_TX :
               pick < 92 ? mcrf_pkg::CMD_CONNECT : pick < 94 ? mcrf_pkg::CMD_HANG_UP :
               pick < 97 ? CMD_SPARE_A : CMD_SPARE_B;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         it.addr = sram_addr();
      end else if (pick < 85) begin
         case ($urandom_range(0, 7))
            0, 1: r = mcrf_pkg::REG_TX_DATA;
            2: r = mcrf_pkg::REG_RX_DATA;
            3: r = mcrf_pkg::REG_RX_READY;
            4, 5: r = mcrf_pkg::REG_MODEM +
                      8'($urandom_range(0, mcrf_pkg::MODEM_ENTRIES - 1));
            default: r = 8'($urandom);
         endcase
         it.addr = reg_addr(r, 1'($urandom_range(0, 1)));
         if (r == mcrf_pkg::REG_MODEM + mcrf_pkg::M_RELAY && $urandom_range(0, 3) != 0)
            it.wdata[1] = 1;
         if (r == mcrf_pkg::REG_MODEM + mcrf_pkg::M_MODE && $urandom_range(0, 1) == 0)
            it.wdata = mcrf_pkg::MODE_KEY;
      end else if (pick < 92) begin
         it.addr = {mcrf_pkg::IO_BANK,
                    $urandom_range(0, 1) ? mcrf_pkg::KILL_OFF : mcrf_pkg::CONTROL_OFF};
      end else begin
         it.addr = 24'($urandom);
      end
      return it;
   endfunction

   // Stimulus.
   initial begin
      bus_item_type it;
      modem_sb.clear();
      repeat (7) @(posedge clock);
      reset <= 0;

      // Directed: map extremes, fixed values, masks and the link commands.
      send_cmd(mcrf_pkg::CMD_READ, 24'h000000, 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, 24'hFFFFFF, 8'hFF, 8'hFF);
      send_cmd(mcrf_pkg::CMD_READ, 24'hE0FFFF, 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, 24'h60FFFF, 8'hFF, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, {mcrf_pkg::IO_BANK, mcrf_pkg::SRAM_IO_TOP}, 8'h5A, 8'h00);
      send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_FIXED_HI, 1'b0), 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_FIXED_LO, 1'b1), 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_ST19, 1'b0),
               8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_MASK_A, 1'b1),
               8'hFF, 8'h00);
      send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_MASK_A, 1'b0),
               8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_MASK_B, 1'b0),
               8'hFF, 8'h00);
      send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_MASK_B, 1'b1),
               8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_MODE, 1'b0),
               mcrf_pkg::MODE_KEY, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_RELAY, 1'b0),
               8'h02, 8'h00);
      send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_LINE, 1'b0),
               8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_DIAL, 1'b0),
               8'h01, 8'h00);
      send_cmd(mcrf_pkg::CMD_CONNECT, 24'h000000, 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, reg_addr(mcrf_pkg::REG_TX_DATA, 1'b1), 8'hC3, 8'h00);
      send_cmd(mcrf_pkg::CMD_TAKE_TX, 24'h000000, 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_LINE_BYTE, 24'h000000, 8'h00, 8'hA5);
      send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_RX_READY, 1'b0), 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_RX_DATA, 1'b0), 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_CONNECT, 24'h000000, 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_WRITE, reg_addr(mcrf_pkg::REG_MODEM + mcrf_pkg::M_RELAY, 1'b1),
               8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_HANG_UP, 24'h000000, 8'h00, 8'h00);

      // Receive-ready answers up to and past the cap on consecutive yes answers.
      send_cmd(mcrf_pkg::CMD_CONNECT, 24'h000000, 8'h00, 8'h00);
      send_cmd(mcrf_pkg::CMD_LINE_BYTE, 24'h000000, 8'h00, 8'h3C);
      repeat (130)
         send_cmd(mcrf_pkg::CMD_READ, reg_addr(mcrf_pkg::REG_RX_READY, 1'b0), 8'h00, 8'h00);

      // Random traffic, restarting the link now and then.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 100 && n < 200);
         if (n == 300) hold_request = 1;
         if (n == 500) begin
            req_valid <= 0;
            @(posedge clock);
            while (modem_sb.awaited.size() > 0) @(posedge clock);
         end
         if (n % 150 == 0)
            send_cmd(mcrf_pkg::CMD_CONNECT, 24'($urandom), 8'($urandom), 8'($urandom));
         it = random_item();
         send_item(it);
      end
      req_valid <= 0;
      calm = 0;

      // Drain the outstanding results.
      while (modem_sb.awaited.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d items; %0d results checked, %0d of them link tear-downs.",
               sent, modem_sb.checked, modem_sb.hangups);
      if (modem_sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
